[rtl/ybr_pkg.sv]
// Package for the YMODEM block receiver: protocol codes, result types and the
// byte-wide CRC-16/XMODEM update function. No dependencies.
package ybr_pkg;

    // Lead bytes of a frame.
    localparam logic [7:0] LEAD_SOH = 8'h01;
    localparam logic [7:0] LEAD_STX = 8'h02;
    localparam logic [7:0] LEAD_EOT = 8'h04;

    // Reply codes.
    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CODE_NAK = 8'h15;
    localparam logic [7:0] CODE_C   = 8'h43;

    localparam logic [7:0]  SEQ_CHECK = 8'hFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam logic [10:0] LEN_NONE  = 11'd0;
    localparam logic [10:0] LEN_SHORT = 11'd128;
    localparam logic [10:0] LEN_LONG  = 11'd1024;
    localparam logic [10:0] COUNT_MAX = 11'd2047;

    // Depth of the result queue; a power of two, at least 4.
    localparam int RESULT_DEPTH_DEFAULT = 4;

    typedef enum logic [1:0] {
        FK_NONE = 2'd0,
        FK_SOH  = 2'd1,
        FK_STX  = 2'd2,
        FK_EOT  = 2'd3
    } frame_kind_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_VERDICT = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        ST_GOOD   = 2'd0,
        ST_EOT    = 2'd1,
        ST_REJECT = 2'd2
    } block_status_t;

    typedef struct packed {
        result_kind_t  kind;
        logic [7:0]    value;
        logic [7:0]    block_number;
        block_status_t status;
        logic [10:0]   data_length;
        logic          last;
    } result_t;

    // One byte of CRC-16/XMODEM, MSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/ybr_frame.sv]
// Frame parser of the YMODEM block receiver: frame state, CRC, verdict and
// reply generation for one accepted byte. Depends on ybr_pkg.
module ybr_frame (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_bit,
    input  logic            in_fire,
    input  logic [7:0]      rx_byte,
    input  logic            frame_end,
    output ybr_pkg::result_t res0,
    output ybr_pkg::result_t res1,
    output logic [1:0]      res_count
);
    import ybr_pkg::*;

    logic        reply_enable_reg;
    logic [10:0] byte_count_reg, byte_count_next;
    frame_kind_t frame_kind_reg, frame_kind_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  comp_reg, comp_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic        eot_pending_reg, eot_pending_next;

    frame_kind_t   kind_cur;
    logic [10:0]   plen;
    logic          has_data;
    logic          in_payload;
    logic [10:0]   cnt_inc;
    logic          hdr_ok;
    logic          good;
    block_status_t status_v;
    logic [7:0]    blk_v;
    logic [10:0]   len_v;
    logic [1:0]    n;

    always_comb
    begin
        if (byte_count_reg == 11'd0)
        begin
            unique case (rx_byte)
                LEAD_SOH: kind_cur = FK_SOH;
                LEAD_STX: kind_cur = FK_STX;
                LEAD_EOT: kind_cur = FK_EOT;
                default:  kind_cur = FK_NONE;
            endcase
        end
        else
        begin
            kind_cur = frame_kind_reg;
        end
    end

    always_comb
    begin
        unique case (kind_cur)
            FK_SOH:  plen = LEN_SHORT;
            FK_STX:  plen = LEN_LONG;
            default: plen = LEN_NONE;
        endcase
    end

    assign has_data   = (plen != LEN_NONE);
    assign in_payload = has_data && (byte_count_reg >= 11'd3)
                        && (byte_count_reg < (plen + 11'd3));
    assign cnt_inc    = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                      : byte_count_reg + 11'd1;

    // Field capture and CRC update for the current byte position.
    always_comb
    begin
        seq_next    = seq_reg;
        comp_next   = comp_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        crc_lo_next = crc_lo_reg;
        if (has_data)
        begin
            if (byte_count_reg == 11'd1)
            begin
                seq_next = rx_byte;
            end
            else if (byte_count_reg == 11'd2)
            begin
                comp_next = rx_byte;
            end
            else if (in_payload)
            begin
                crc_next = crc_step(crc_reg, rx_byte);
            end
            else if (byte_count_reg == plen + 11'd3)
            begin
                crc_hi_next = rx_byte;
            end
            else if (byte_count_reg == plen + 11'd4)
            begin
                crc_lo_next = rx_byte;
            end
        end
    end

    assign hdr_ok = ((seq_next | comp_next) == SEQ_CHECK);
    assign good   = has_data && hdr_ok && (cnt_inc >= plen + 11'd5)
                    && (crc_next == {crc_hi_next, crc_lo_next});

    always_comb
    begin
        if (good)
        begin
            status_v = ST_GOOD;
            blk_v    = seq_next;
            len_v    = plen;
        end
        else
        begin
            status_v = (!has_data && kind_cur == FK_EOT) ? ST_EOT : ST_REJECT;
            blk_v    = 8'd0;
            len_v    = LEN_NONE;
        end
    end

    // Result generation: a payload byte, or one or two results at frame end.
    always_comb
    begin
        res0             = '{KIND_PAYLOAD, 8'd0, blk_v, status_v, len_v, 1'b1};
        res1             = '{KIND_REPLY, CODE_C, blk_v, status_v, len_v, 1'b1};
        n                = 2'd0;
        eot_pending_next = eot_pending_reg;
        if (!frame_end)
        begin
            res0 = '{KIND_PAYLOAD, rx_byte, seq_next, ST_GOOD, plen, 1'b0};
            if (in_payload && hdr_ok)
            begin
                n = 2'd1;
            end
        end
        else if (!reply_enable_reg)
        begin
            res0.kind = KIND_VERDICT;
            n         = 2'd1;
        end
        else
        begin
            res0.kind = KIND_REPLY;
            unique case (status_v)
                ST_REJECT:
                begin
                    res0.value = CODE_NAK;
                    n          = 2'd1;
                end
                ST_GOOD:
                begin
                    res0.value = CODE_ACK;
                    if (blk_v == 8'd0)
                    begin
                        res0.last        = 1'b0;
                        n                = 2'd2;
                        eot_pending_next = 1'b0;
                    end
                    else
                    begin
                        n = 2'd1;
                    end
                end
                default:
                begin
                    if (!eot_pending_reg)
                    begin
                        res0.value       = CODE_NAK;
                        n                = 2'd1;
                        eot_pending_next = 1'b1;
                    end
                    else
                    begin
                        res0.value       = CODE_ACK;
                        res0.last        = 1'b0;
                        n                = 2'd2;
                        eot_pending_next = 1'b0;
                    end
                end
            endcase
        end
    end

    assign res_count = in_fire ? n : 2'd0;

    always_comb
    begin
        byte_count_next = cnt_inc;
        frame_kind_next = kind_cur;
        if (frame_end)
        begin
            byte_count_next = 11'd0;
            frame_kind_next = FK_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_enable_reg <= 1'b1;
            byte_count_reg   <= 11'd0;
            frame_kind_reg   <= FK_NONE;
            seq_reg          <= 8'd0;
            comp_reg         <= 8'd0;
            crc_reg          <= 16'd0;
            crc_hi_reg       <= 8'd0;
            crc_lo_reg       <= 8'd0;
            eot_pending_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                reply_enable_reg <= cfg_bit;
            end
            if (in_fire)
            begin
                byte_count_reg  <= byte_count_next;
                frame_kind_reg  <= frame_kind_next;
                eot_pending_reg <= eot_pending_next;
                if (frame_end)
                begin
                    seq_reg    <= 8'd0;
                    comp_reg   <= 8'd0;
                    crc_reg    <= 16'd0;
                    crc_hi_reg <= 8'd0;
                    crc_lo_reg <= 8'd0;
                end
                else
                begin
                    seq_reg    <= seq_next;
                    comp_reg   <= comp_next;
                    crc_reg    <= crc_next;
                    crc_hi_reg <= crc_hi_next;
                    crc_lo_reg <= crc_lo_next;
                end
            end
        end
    end

    // A pair of results is always a reply followed by the closing C.
    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_count == 2'd2) |-> (!res0.last && res1.last && res0.value == CODE_ACK))
        else $error("two-result frame end is not ACK followed by C");

    // A forwarded payload byte never closes a frame.
    a_payload_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_count == 2'd1 && res0.kind == KIND_PAYLOAD) |-> (!res0.last && !frame_end))
        else $error("payload result marked as last");

endmodule

[rtl/ybr_out_fifo.sv]
// Result queue of the YMODEM block receiver: takes up to two results per
// cycle and hands out one per cycle while out_ready is high. Depends on ybr_pkg.
module ybr_out_fifo #(
    parameter int DEPTH = ybr_pkg::RESULT_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  ybr_pkg::result_t push0,
    input  ybr_pkg::result_t push1,
    output logic             room2,
    output logic             out_valid,
    input  logic             out_ready,
    output ybr_pkg::result_t out_data
);
    import ybr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    assign out_valid   = (count_reg != CW'(0));
    assign out_data    = mem[rd_ptr_reg];
    assign pop         = out_valid && out_ready;
    assign room2       = (count_reg <= CW'(DEPTH - 2));
    assign wr_ptr_next = wr_ptr_reg + AW'(push_count);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + CW'(push_count) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_reg + AW'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Writes only arrive when two slots are free, so the queue never overflows.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_count != 2'd0) |-> (count_reg <= CW'(DEPTH - 2)))
        else $error("result queue written without room");

    // Occupancy agrees with the pointer distance.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CW'(DEPTH)) |-> (AW'(wr_ptr_reg - rd_ptr_reg) == AW'(count_reg)))
        else $error("result queue pointers and count disagree");

endmodule

[rtl/ymodem_block_receiver.sv]
// YMODEM block receiver: results pass through the result queue, which registers
// them for the master side. One byte is accepted every cycle while the result
// queue (four entries by default) has two free slots; an ACK+C reply is two
// results. Reset (rst_n, asynchronous, active low) clears the frame state and the
// pending-EOT flag, sets reply_enable to 1 and empties the result queue.
module ymodem_block_receiver #(
    parameter int RESULT_DEPTH = ybr_pkg::RESULT_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // frame_end
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] value, [15:8] block_number,
                                   // [17:16] status, [28:18] data_length, rest 0
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // last
    // Configuration: reply_enable.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import ybr_pkg::*;

    // The parser works on the accepted byte in a single pass: it updates the
    // frame state and CRC and produces zero, one or two results, which are
    // written into the result queue in the same transaction. The queue acts as
    // the output register: bytes flow on while results wait, if two slots are free.
    logic       in_fire;
    result_t    res0;
    result_t    res1;
    logic [1:0] res_count;
    logic       room2;
    result_t    out_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = room2;
    assign in_fire   = s_tvalid && s_tready;

    ybr_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_bit   (cfg_data),
        .in_fire   (in_fire),
        .rx_byte   (s_tdata),
        .frame_end (s_tlast),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    ybr_out_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .room2      (room2),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    // Pack the result fields onto the stream bus.
    assign m_tdata = {3'b000, out_data.data_length, out_data.status,
                      out_data.block_number, out_data.value};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

endmodule
